>>> src/hilbert_index_2d_defines.svh
// Assertion macros used by the output stage of the Hilbert index block.
`ifndef HILBERT_INDEX_2D_DEFINES_SVH
`define HILBERT_INDEX_2D_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HIDX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HIDX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/hidx_pkg.sv
// Shared types, constants and widths for the Hilbert index block.
package hidx_pkg;

  localparam int COORD_BITS_DEF = 64;
  localparam int FIELD_W        = 64;
  localparam int INDEX_W        = 2 * FIELD_W;

  // Orientation table, bit {r,c}: a00 in bit 0, a01 in bit 1, a10 in bit 2, a11 in bit 3.
  localparam logic [3:0] TBL_INIT = 4'b1100;

  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
    logic [3:0]         tbl;
    logic [INDEX_W-1:0] idx;
  } hidx_lane_t;

endpackage

>>> src/hidx_coord_if.sv
// Request channel carrying one coordinate pair.
interface hidx_coord_if;
  import hidx_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] coord_row;
  logic [FIELD_W-1:0] coord_col;

  modport source (output valid, output coord_row, output coord_col, input ready);
  modport sink (input valid, input coord_row, input coord_col, output ready);
endinterface

>>> src/hidx_index_if.sv
// Request channel carrying one Hilbert index split into two halves.
interface hidx_index_if;
  import hidx_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] index_high;
  logic [FIELD_W-1:0] index_low;

  modport source (output valid, output index_high, output index_low, input ready);
  modport sink (input valid, input index_high, input index_low, output ready);
endinterface

>>> src/hidx_cell.sv
// One bit level of the Hilbert mapping, registered towards the next cell.
module hidx_cell #(
  parameter int LEVEL = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  hidx_pkg::hidx_lane_t lane_in,
  output hidx_pkg::hidx_lane_t lane_out
);
  import hidx_pkg::*;

  logic       r;
  logic       c;
  logic       first;
  logic       second;
  logic       valid;
  hidx_lane_t lane;
  hidx_lane_t lane_next;

  always_comb begin
    r      = lane_in.row[LEVEL];
    c      = lane_in.col[LEVEL];
    first  = lane_in.tbl[{r, c}];
    second = ~(r ^ c);
    lane_next = lane_in;
    lane_next.idx[2*LEVEL+1] = first;
    lane_next.idx[2*LEVEL]   = second;
    // The table only reorients when both emitted bits agree.
    if (first == second) begin
      if (r != c) begin
        lane_next.tbl[0] = lane_in.tbl[3];
        lane_next.tbl[3] = lane_in.tbl[0];
      end else begin
        lane_next.tbl[1] = lane_in.tbl[2];
        lane_next.tbl[2] = lane_in.tbl[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= lane_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane <= lane_next;
    end
  end

  always_comb begin
    lane_out       = lane;
    lane_out.valid = valid;
  end

endmodule

>>> src/hidx_out.sv
// Output register with a skid stage that decouples the cell chain from the receiver.
`include "hilbert_index_2d_defines.svh"

module hidx_out #(
  parameter int COORD_BITS = hidx_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hidx_pkg::hidx_lane_t lane,
  output logic                 take,
  hidx_index_if.source         index
);
  import hidx_pkg::*;

  localparam logic [FIELD_W-1:0] LOW_MASK = {FIELD_W{1'b1}} >> (FIELD_W - COORD_BITS);

  logic               out_valid;
  logic [INDEX_W-1:0] out_idx;
  logic               skid_valid;
  logic [INDEX_W-1:0] skid_idx;
  logic [INDEX_W-1:0] idx_high;
  logic               skid_catch;
  logic               skid_drain;

  // The chain only moves while the skid stage is empty.
  assign take = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (index.ready) begin
        out_idx    <= skid_idx;
        skid_valid <= 1'b0;
      end
    end else if (lane.valid) begin
      if (!out_valid || index.ready) begin
        out_idx   <= lane.idx;
        out_valid <= 1'b1;
      end else begin
        skid_idx   <= lane.idx;
        skid_valid <= 1'b1;
      end
    end else if (index.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign idx_high         = out_idx >> COORD_BITS;
  assign index.valid      = out_valid;
  assign index.index_high = idx_high[FIELD_W-1:0];
  assign index.index_low  = out_idx[FIELD_W-1:0] & LOW_MASK;

  assign skid_catch = !skid_valid && lane.valid && out_valid && !index.ready;
  assign skid_drain = skid_valid && index.ready;

  `HIDX_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid full with output empty")
  `HIDX_ASSERT_NEXT(a_skid_fill, skid_catch, skid_valid, "stalled request not caught by skid")
  `HIDX_ASSERT_NEXT(a_skid_drain, skid_drain, !skid_valid && out_valid, "skid did not drain")
  `HIDX_ASSERT_NEXT(a_out_load, !skid_valid && lane.valid, out_valid, "request from chain lost")

endmodule

>>> src/hilbert_index_2d.sv
// Top level of the two-dimensional Hilbert index block.
//
// Usage: coordinate pairs arrive on the coord channel (coord_row, coord_col) and
// each yields one Hilbert index on the index channel (index_high, index_low).
// Both channels use valid/ready; a request moves when both are high at a clock edge.
// Coordinate bits at or above COORD_BITS are ignored.
// The work runs through a chain of COORD_BITS cells, one per bit level from the
// most significant down, each passing the orientation table to its neighbour.
// Each cell registers its level, and the output register follows the last cell.
// Throughput: one request per cycle while the receiver keeps ready high.
// When the receiver stalls, the result waits in the output register and one more
// result is caught by a skid stage; only then does coord.ready fall and the
// whole chain hold. coord.ready comes straight from a register.
// Reset (rst, synchronous) empties the chain, the output register and the skid stage.
module hilbert_index_2d #(
  parameter int COORD_BITS = hidx_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hidx_coord_if.sink   coord,
  hidx_index_if.source index
);
  import hidx_pkg::*;

  hidx_lane_t stage [0:COORD_BITS];
  logic       take;

  assign coord.ready = take;

  always_comb begin
    stage[0].valid = coord.valid & take;
    stage[0].row   = coord.coord_row;
    stage[0].col   = coord.coord_col;
    stage[0].tbl   = TBL_INIT;
    stage[0].idx   = '0;
  end

  for (genvar k = 0; k < COORD_BITS; k++) begin : g_cell
    hidx_cell #(
      .LEVEL(COORD_BITS - 1 - k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (take),
      .lane_in (stage[k]),
      .lane_out(stage[k+1])
    );
  end

  hidx_out #(
    .COORD_BITS(COORD_BITS)
  ) u_out (
    .clk  (clk),
    .rst  (rst),
    .lane (stage[COORD_BITS]),
    .take (take),
    .index(index)
  );

endmodule

>>> dv/tb_hilbert_index_2d.sv
// Self-checking testbench for the two-dimensional Hilbert index block.
module tb_hilbert_index_2d;
  import hidx_pkg::*;

  localparam int CB          = COORD_BITS_DEF;
  localparam int LATENCY     = CB + 1;
  localparam int CYCLE_LIMIT = 200000;

  // Orientation table indexed by {row bit, column bit}: a00=0, a01=0, a10=1, a11=1.
  localparam bit [3:0] ORIENT_START = 4'b1100;

  typedef struct packed {
    logic [FIELD_W-1:0] high;
    logic [FIELD_W-1:0] low;
  } hilbert_index_t;

  logic clk;
  logic rst = 1'b1;

  hidx_coord_if coord_bus ();
  hidx_index_if index_bus ();

  hilbert_index_2d #(.COORD_BITS(CB)) uut (
    .clk   (clk),
    .rst   (rst),
    .coord (coord_bus),
    .index (index_bus)
  );

  hilbert_index_t pending_index[$];
  int             mismatches    = 0;
  int             cycle_count   = 0;
  bit             sender_idles  = 1'b1;
  bit             receiver_idles = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Walks the bit levels from the top, steering the orientation table as it goes.
  function automatic hilbert_index_t hilbert_position(logic [FIELD_W-1:0] row,
                                                      logic [FIELD_W-1:0] col);
    bit [3:0]        orient;
    bit [2*CB-1:0]   pos;
    bit              r;
    bit              c;
    bit              first;
    bit              second;
    int              lvl;
    hilbert_index_t  res;
    orient = ORIENT_START;
    pos    = '0;
    for (lvl = CB - 1; lvl >= 0; lvl--) begin
      r      = row[lvl];
      c      = col[lvl];
      first  = orient[{r, c}];
      second = (r == c);
      pos[2*lvl+1] = first;
      pos[2*lvl]   = second;
      if (first == second) begin
        if (r != c) begin
          {orient[0], orient[3]} = {orient[3], orient[0]};
        end else begin
          {orient[1], orient[2]} = {orient[2], orient[1]};
        end
      end
    end
    res.high = FIELD_W'(pos >> CB);
    res.low  = FIELD_W'(pos[CB-1:0]);
    return res;
  endfunction

  function automatic logic [FIELD_W-1:0] random_coord();
    return {$urandom, $urandom};
  endfunction

  // Sends one coordinate request and records the index it must produce.
  task automatic send_coords(logic [FIELD_W-1:0] row, logic [FIELD_W-1:0] col);
    int gap;
    gap = sender_idles ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      coord_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coord_bus.valid     <= 1'b1;
    coord_bus.coord_row <= row;
    coord_bus.coord_col <= col;
    do @(posedge clk); while (coord_bus.ready !== 1'b1);
    pending_index.push_back(hilbert_position(row, col));
  endtask

  // Receiver: stalls at random, then compares each result with the oldest expectation.
  initial begin
    int             stall;
    hilbert_index_t want;
    index_bus.ready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = receiver_idles ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        index_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      index_bus.ready <= 1'b1;
      do @(posedge clk); while (index_bus.valid !== 1'b1);
      if (pending_index.size() == 0) begin
        $display("%0t: result with nothing expected: high %h low %h", $time,
                 index_bus.index_high, index_bus.index_low);
        mismatches++;
      end else begin
        want = pending_index.pop_front();
        if (index_bus.index_high !== want.high) begin
          $display("%0t: index_high expected %h actual %h", $time, want.high,
                   index_bus.index_high);
          mismatches++;
        end
        if (index_bus.index_low !== want.low) begin
          $display("%0t: index_low expected %h actual %h", $time, want.low,
                   index_bus.index_low);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("hilbert_index_2d regression: fail");
    $finish;
  end

  // Extremes of both coordinates and patterns that force each table swap.
  task automatic test_corners();
    logic [FIELD_W-1:0] ones;
    ones = '1;
    send_coords('0, '0);
    send_coords(ones, ones);
    send_coords(ones, '0);
    send_coords('0, ones);
    send_coords(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_coords(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_coords(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
    send_coords(64'h8000_0000_0000_0000, 64'h0);
    send_coords(64'h0, 64'h8000_0000_0000_0000);
    send_coords(64'h1, 64'h0);
    send_coords(64'h0, 64'h1);
    send_coords(64'h1, 64'h1);
    send_coords(64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_fffe);
    send_coords(64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000);
  endtask

  // Equal and complementary coordinates keep taking one swap branch level after level.
  task automatic test_swap_paths();
    logic [FIELD_W-1:0] v;
    repeat (4) begin
      v = random_coord();
      send_coords(v, v);
      send_coords(v, ~v);
    end
  endtask

  // Back-to-back requests with neither side idling.
  task automatic test_streaming(int count);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    repeat (count) send_coords(random_coord(), random_coord());
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  task automatic test_random(int count);
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
    int                 kind;
    for (int n = 0; n < count; n++) begin
      // Change the idling pattern every hundred requests or so.
      if (n % 100 == 0) begin
        sender_idles   = $urandom_range(0, 3) != 0;
        receiver_idles = $urandom_range(0, 3) != 0;
      end
      kind = $urandom_range(0, 9);
      row  = random_coord();
      col  = random_coord();
      case (kind)
        0: begin
          row = row >> $urandom_range(0, 63);
          col = col >> $urandom_range(0, 63);
        end
        1: col = row ^ (64'h1 << $urandom_range(0, 63));
        2: col = ~row;
        default: ;
      endcase
      send_coords(row, col);
    end
  endtask

  initial begin
    coord_bus.valid     <= 1'b0;
    coord_bus.coord_row <= '0;
    coord_bus.coord_col <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corners();
    test_swap_paths();
    test_streaming(200);
    test_random(1320);

    coord_bus.valid <= 1'b0;
    while (pending_index.size() > 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("hilbert_index_2d regression: pass");
    end else begin
      $display("hilbert_index_2d regression: fail");
    end
    $finish;
  end

endmodule
